>>> hw/rtl/rems_pkg.sv
package rems_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;
  localparam int CUTOFF_SLOTS_DEFAULT = 4;
  localparam int COST_FRACTION_BITS_DEFAULT = 16;

  localparam logic [3:0] REG_BUDGET = 4'd0;
  localparam logic [3:0] REG_STEP_COUNT = 4'd1;
  localparam logic [3:0] REG_USE_MIN_ENDPOINT = 4'd2;
  localparam logic [3:0] REG_CUTOFF_COUNT = 4'd3;
  localparam logic [3:0] REG_CUTOFF_FIRST = 4'd4;

  typedef struct packed {
    logic signed [63:0] edge_id;
    logic [31:0] src_cost;
    logic [31:0] dst_cost;
    logic source_ok;
    logic target_ok;
    logic last_edge;
  } item_t;

  typedef struct packed {
    logic signed [63:0] out_edge_id;
    logic [31:0] edge_cost;
    logic [31:0] step_cost;
    logic [31:0] from_cost;
    logic [31:0] to_cost;
    logic overflow;
    logic last;
  } result_t;

  typedef struct packed {
    logic valid;
    logic signed [63:0] id;
    logic [31:0] cost;
    logic [31:0] step_cost;
    logic [31:0] src_cost;
    logic [31:0] dst_cost;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_UPDATE,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic modify;
    logic insert;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_STEP,
    ST_DIV_COST,
    ST_UPDATE,
    ST_EMIT
  } state_t;

endpackage

>>> hw/rtl/reached_edge_min_table_sorted.sv
// Channel  | Handshake               | Word
// input    | start, busy             | item (edge id, endpoint costs, flags)
// config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
// result   | result_valid (strobe)   | result (entry fields, overflow, last)
//
// A skipped item, or one with cutoffs or without steps, goes straight to update.
// In step mode the shared radix-2 divider divides the budget by the step count;
// when that step size is nonzero, a second pass divides the cost by it, and when
// it is zero the item goes straight to update. After a last edge the cell chain
// shifts its stored entries out, one entry per cycle, until it is empty. Reset
// is synchronous and empties the chain.
// Results cannot be stalled; config writes are always taken.
module reached_edge_min_table_sorted #(
  parameter int TABLE_DEPTH = rems_pkg::TABLE_DEPTH_DEFAULT,
  parameter int CUTOFF_SLOTS = rems_pkg::CUTOFF_SLOTS_DEFAULT,
  parameter int COST_FRACTION_BITS = rems_pkg::COST_FRACTION_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rems_pkg::item_t   item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              result_valid,
  output rems_pkg::result_t result
);

  rems_pkg::state_t state;
  rems_pkg::state_t state_next;

  logic [31:0] budget;
  logic [15:0] step_count;
  logic        use_min_endpoint;
  logic [2:0]  cutoff_count;
  logic [15:0] cutoff [CUTOFF_SLOTS];

  logic signed [63:0] cur_id;
  logic [31:0] cur_cost;
  logic [31:0] cur_sc;
  logic [31:0] cur_tc;
  logic [31:0] cur_snap;
  logic [31:0] step_len;
  logic        cur_take;
  logic        cur_last;
  logic        cur_div;
  logic        dropped;

  logic [31:0] in_lo;
  logic [31:0] in_cost;
  logic        in_take;
  logic [2:0]  used;
  logic [31:0] cut_val [CUTOFF_SLOTS];
  logic [31:0] cut_snap;
  logic        accept;

  logic        div_go;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [31:0] div_quo;
  logic [31:0] div_rem;
  logic [32:0] rounded;

  rems_pkg::cell_ctrl_t ctrl;
  rems_pkg::entry_t     fresh;
  rems_pkg::entry_t     cells [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_ge;
  logic [TABLE_DEPTH-1:0] cell_match;
  logic                 any_match;
  logic                 full;
  logic                 next_valid;

  assign accept = start && !busy;
  assign busy = (state != rems_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= '1;
      step_count <= '0;
      use_min_endpoint <= 1'b0;
      cutoff_count <= '0;
      for (int k = 0; k < CUTOFF_SLOTS; k++) begin
        cutoff[k] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rems_pkg::REG_BUDGET: budget <= cfg_data;
        rems_pkg::REG_STEP_COUNT: step_count <= cfg_data[15:0];
        rems_pkg::REG_USE_MIN_ENDPOINT: use_min_endpoint <= cfg_data[0];
        rems_pkg::REG_CUTOFF_COUNT: cutoff_count <= cfg_data[2:0];
        default: begin
          for (int k = 0; k < CUTOFF_SLOTS; k++) begin
            if (cfg_index == rems_pkg::REG_CUTOFF_FIRST + 4'(k)) begin
              cutoff[k] <= cfg_data[15:0];
            end
          end
        end
      endcase
    end
  end

  assign in_lo = (item.src_cost < item.dst_cost) ? item.src_cost : item.dst_cost;
  assign in_cost = use_min_endpoint ? in_lo : item.dst_cost;
  assign in_take = item.source_ok && item.target_ok && (in_lo <= budget);
  assign used = (cutoff_count > 3'(CUTOFF_SLOTS)) ? 3'(CUTOFF_SLOTS) : cutoff_count;

  always_comb begin
    logic [63:0] wide;
    logic        found;
    logic [31:0] last_cut;
    found = 1'b0;
    last_cut = '0;
    cut_snap = in_cost;
    for (int k = 0; k < CUTOFF_SLOTS; k++) begin
      wide = 64'(cutoff[k]) << COST_FRACTION_BITS;
      cut_val[k] = (|wide[63:32]) ? '1 : wide[31:0];
      if ((3'(k) < used) && !found && (in_cost <= cut_val[k])) begin
        cut_snap = cut_val[k];
        found = 1'b1;
      end
      if (3'(k) + 3'd1 == used) begin
        last_cut = cut_val[k];
      end
    end
    if ((used != 3'd0) && !found) begin
      cut_snap = last_cut;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_id <= item.edge_id;
      cur_cost <= in_cost;
      cur_sc <= item.src_cost;
      cur_tc <= item.dst_cost;
      cur_snap <= cut_snap;
      cur_take <= in_take;
      cur_last <= item.last_edge;
      cur_div <= in_take && (used == 3'd0) && (step_count != 16'd0);
    end else if (state == rems_pkg::ST_DIV_STEP && div_done) begin
      step_len <= div_quo;
    end else if (state == rems_pkg::ST_DIV_COST && div_done) begin
      cur_snap <= rounded[32] ? '1 : rounded[31:0];
    end
  end

  assign rounded = 33'(cur_cost) - 33'(div_rem) + ((div_rem != 32'd0) ? 33'(step_len) : 33'd0);

  always_comb begin
    div_go = 1'b0;
    div_dividend = budget;
    div_divisor = 32'(step_count);
    if (accept && in_take && (used == 3'd0) && (step_count != 16'd0)) begin
      div_go = 1'b1;
    end else if (state == rems_pkg::ST_DIV_STEP && div_done && div_quo != 32'd0) begin
      div_go = 1'b1;
      div_dividend = cur_cost;
      div_divisor = div_quo;
    end
  end

  rems_divider u_div (
    .clk(clk),
    .rst(rst),
    .go(div_go),
    .dividend(div_dividend),
    .divisor(div_divisor),
    .done(div_done),
    .quotient(div_quo),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rems_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rems_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (in_take && (used == 3'd0) && (step_count != 16'd0)) ?
                       rems_pkg::ST_DIV_STEP : rems_pkg::ST_UPDATE;
        end
      end
      rems_pkg::ST_DIV_STEP: begin
        if (div_done) begin
          state_next = (div_quo != 32'd0) ? rems_pkg::ST_DIV_COST : rems_pkg::ST_UPDATE;
        end
      end
      rems_pkg::ST_DIV_COST: begin
        if (div_done) begin
          state_next = rems_pkg::ST_UPDATE;
        end
      end
      rems_pkg::ST_UPDATE: begin
        state_next = cur_last ? rems_pkg::ST_EMIT : rems_pkg::ST_IDLE;
      end
      rems_pkg::ST_EMIT: begin
        if (!cells[0].valid) begin
          state_next = rems_pkg::ST_IDLE;
        end
      end
      default: state_next = rems_pkg::ST_IDLE;
    endcase
  end

  assign any_match = |cell_match;
  assign full = cells[TABLE_DEPTH-1].valid;

  always_comb begin
    ctrl.op = rems_pkg::OP_HOLD;
    ctrl.modify = 1'b0;
    ctrl.insert = 1'b0;
    unique case (state)
      rems_pkg::ST_UPDATE: begin
        ctrl.op = rems_pkg::OP_UPDATE;
        ctrl.modify = cur_take;
        ctrl.insert = cur_take && !any_match && !full;
      end
      rems_pkg::ST_EMIT: ctrl.op = rems_pkg::OP_SHIFT;
      default: ctrl.op = rems_pkg::OP_HOLD;
    endcase
  end

  assign fresh.valid = 1'b1;
  assign fresh.id = cur_id;
  assign fresh.cost = cur_cost;
  assign fresh.step_cost = cur_div ? cur_snap : ((used == 3'd0) ? cur_cost : cur_snap);
  assign fresh.src_cost = cur_sc;
  assign fresh.dst_cost = cur_tc;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    rems_pkg::entry_t left_e;
    rems_pkg::entry_t right_e;
    logic left_g;
    if (g == 0) begin : g_head
      assign left_e = '0;
      assign left_g = 1'b0;
    end else begin : g_body
      assign left_e = cells[g-1];
      assign left_g = cell_ge[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid
      assign right_e = cells[g+1];
    end
    rems_cell u_cell (
      .clk(clk),
      .rst(rst),
      .ctrl(ctrl),
      .fresh(fresh),
      .left_entry(left_e),
      .left_ge(left_g),
      .right_entry(right_e),
      .entry(cells[g]),
      .ge(cell_ge[g]),
      .match(cell_match[g])
    );
  end

  if (TABLE_DEPTH > 1) begin : g_next
    assign next_valid = cells[1].valid;
  end else begin : g_single
    assign next_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dropped <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == rems_pkg::ST_EMIT) && cells[0].valid;
      if (state == rems_pkg::ST_UPDATE && cur_take && !any_match && full) begin
        dropped <= 1'b1;
      end else if (state == rems_pkg::ST_EMIT && !cells[0].valid) begin
        dropped <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == rems_pkg::ST_EMIT) begin
      result.out_edge_id <= cells[0].id;
      result.edge_cost <= cells[0].cost;
      result.step_cost <= cells[0].step_cost;
      result.from_cost <= cells[0].src_cost;
      result.to_cost <= cells[0].dst_cost;
      result.overflow <= dropped;
      result.last <= !next_valid;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted word did not raise busy");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("word after the last word of a run");
  a_compact: assert property (@(posedge clk) disable iff (rst)
    !cells[0].valid |-> !full) else $error("cell chain has a gap at its head");
  a_strobe_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == rems_pkg::ST_EMIT)
    else $error("result word outside the emission run");
`endif

endmodule

>>> hw/rtl/rems_divider.sv
module rems_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic        running;
  logic [4:0]  count;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] shifted;
  logic        fits;

  assign shifted = {rem, quo[31]};
  assign fits = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        count <= '0;
      end else if (running) begin
        count <= count + 5'd1;
        if (count == 5'd31) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      quo <= {quo[30:0], fits};
      rem <= fits ? 32'(shifted - {1'b0, dvs}) : shifted[31:0];
    end
  end

  assign quotient = quo;
  assign remainder = rem;

endmodule

>>> hw/rtl/rems_cell.sv
module rems_cell (
  input  logic                clk,
  input  logic                rst,
  input  rems_pkg::cell_ctrl_t ctrl,
  input  rems_pkg::entry_t    fresh,
  input  rems_pkg::entry_t    left_entry,
  input  logic                left_ge,
  input  rems_pkg::entry_t    right_entry,
  output rems_pkg::entry_t    entry,
  output logic                ge,
  output logic                match
);

  rems_pkg::entry_t entry_next;

  assign ge = !entry.valid || (entry.id > fresh.id);
  assign match = entry.valid && (entry.id == fresh.id);

  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      rems_pkg::OP_UPDATE: begin
        if (match && ctrl.modify && (fresh.cost < entry.cost)) begin
          entry_next = fresh;
        end else if (ctrl.insert) begin
          if (left_ge) begin
            entry_next = left_entry;
          end else if (ge) begin
            entry_next = fresh;
          end
        end
      end
      rems_pkg::OP_SHIFT: entry_next = right_entry;
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.id <= entry_next.id;
    entry.cost <= entry_next.cost;
    entry.step_cost <= entry_next.step_cost;
    entry.src_cost <= entry_next.src_cost;
    entry.dst_cost <= entry_next.dst_cost;
  end

endmodule
